>>> hdl/fp32_fp16_converter_assert.svh
`ifndef FP32_FP16_CONVERTER_ASSERT_SVH
`define FP32_FP16_CONVERTER_ASSERT_SVH
// implication check under synchronous reset
`define FCV_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication check
`define FCV_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> hdl/fcv_pkg.sv
package fcv_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned STAGES = 3;
   localparam logic KIND_S2H = 1'b0;
   localparam logic KIND_H2S = 1'b1;
   localparam logic [30:0] HALF_MIN_NORM = 31'h38800000;
   localparam logic [30:0] HALF_MAX_NORM = 31'h477FE000;
   localparam logic [30:0] SINGLE_INF = 31'h7F800000;
   localparam logic [30:0] NAN_SMALL = 31'h7F802000;
   localparam logic [17:0] REBIAS_NORM = 18'h1C000;
   localparam logic [17:0] REBIAS_NAN = 18'h38000;
   localparam logic [14:0] HALF_INF = 15'h7C00;
   localparam logic [14:0] HALF_QNAN = 15'h7C01;

   typedef enum logic [2:0] {
      CLS_ZERO,
      CLS_SUB,
      CLS_NORM,
      CLS_INF,
      CLS_NANS,
      CLS_NANL
   } cls_type;

   typedef struct packed {
      logic       kind;
      logic       sign;
      cls_type    cls;
      logic [30:0] mag;
   } stage_type;
endpackage

>>> hdl/fcv_classify.sv
module fcv_classify (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_kind,
   input  logic [31:0]       in_operand,
   output logic              out_valid,
   output fcv_pkg::stage_type out_stage
);
   import fcv_pkg::*;

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic [30:0] a;

   always_comb begin
      a = in_operand[30:0];
      valid_in = in_valid;
      stage_in.kind = in_kind;
      if (in_kind == KIND_H2S) begin
         stage_in.sign = in_operand[15];
         stage_in.mag = {16'd0, in_operand[14:0]};
         if (in_operand[14:0] == 15'd0) stage_in.cls = CLS_ZERO;
         else if (in_operand[14:10] == 5'd0) stage_in.cls = CLS_SUB;
         else if (in_operand[14:10] != 5'h1F) stage_in.cls = CLS_NORM;
         else stage_in.cls = CLS_NANL;
      end else begin
         stage_in.sign = in_operand[31];
         stage_in.mag = a;
         if (a < HALF_MIN_NORM) stage_in.cls = CLS_SUB;
         else if (a <= HALF_MAX_NORM) stage_in.cls = CLS_NORM;
         else if (a <= SINGLE_INF) stage_in.cls = CLS_INF;
         else if (a < NAN_SMALL) stage_in.cls = CLS_NANS;
         else stage_in.cls = CLS_NANL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

>>> hdl/fcv_align.sv
module fcv_align (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fcv_pkg::stage_type in_stage,
   output logic               out_valid,
   output fcv_pkg::stage_type out_stage,
   output logic [23:0]        out_shifted,
   output logic [3:0]         out_lead
);
   import fcv_pkg::*;

   logic        valid_ff;
   stage_type   stage_ff;
   logic [23:0] shifted_ff, shifted_in;
   logic [3:0]  lead_ff, lead_in;
   logic [7:0]  e;
   logic [7:0]  sh;

   always_comb begin
      e = in_stage.mag[30:23];
      sh = 8'd126 - e;
      shifted_in = 24'd0;
      if (e != 8'd0 && sh < 8'd32) shifted_in = {1'b1, in_stage.mag[22:0]} >> sh[4:0];
      lead_in = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (in_stage.mag[i]) lead_in = 4'(i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      stage_ff <= in_stage;
      shifted_ff <= shifted_in;
      lead_ff <= lead_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
   assign out_shifted = shifted_ff;
   assign out_lead = lead_ff;
endmodule

>>> hdl/fcv_pack.sv
module fcv_pack (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  fcv_pkg::stage_type in_stage,
   input  logic [23:0]        in_shifted,
   input  logic [3:0]         in_lead,
   output logic               out_valid,
   output logic [31:0]        out_result
);
   import fcv_pkg::*;

   logic        valid_ff;
   logic [31:0] result_ff, result_in;
   logic [14:0] h;
   logic [17:0] a13;
   logic [22:0] frac;
   logic [7:0]  exp_s;

   always_comb begin
      a13 = in_stage.mag[30:13];
      h = 15'd0;
      unique case (in_stage.cls)
         CLS_SUB:  h = in_shifted[14:0];
         CLS_NORM: h = 15'(a13 - REBIAS_NORM);
         CLS_INF:  h = HALF_INF;
         CLS_NANS: h = HALF_QNAN;
         CLS_NANL: h = 15'(a13 - REBIAS_NAN);
         default:  h = 15'd0;
      endcase
      frac = 23'({13'd0, in_stage.mag[9:0]} << (5'd23 - {1'b0, in_lead}));
      exp_s = 8'd103 + {4'd0, in_lead};
      if (in_stage.kind == KIND_S2H) begin
         result_in = {16'd0, in_stage.sign, h};
      end else begin
         unique case (in_stage.cls)
            CLS_ZERO: result_in = {in_stage.sign, 31'd0};
            CLS_SUB:  result_in = {in_stage.sign, exp_s, frac};
            CLS_NORM: result_in = {in_stage.sign, 31'({16'd0, in_stage.mag[14:0]}
                                   + 31'h1C000) << 13};
            default:  result_in = {in_stage.sign, 31'({16'd0, in_stage.mag[14:0]}
                                   + 31'h38000) << 13};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= in_valid;
      result_ff <= result_in;
   end

   assign out_valid = valid_ff;
   assign out_result = result_ff;
endmodule

>>> hdl/fp32_fp16_converter.sv
// fp32_fp16_converter: IEEE single <-> half bit pattern conversion.
// Request channel: drive req_kind (0 single to half, 1 half to single) and
// req_operand with start high; the request is taken at any edge where busy
// is low. busy is always low, so one request may enter every cycle.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_result
// after the request passes the classify, align and pack registers in turn.
// Throughput: one request per cycle, set by the three-stage pipeline.
// Results leave in request order; the receiver cannot stall, so nothing is
// held back. Reset clears all stage valid bits; requests in flight are
// dropped and no strobe follows for them.
// Half results sit in rsp_result[15:0] with the upper half zero.
module fp32_fp16_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_operand,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result
);
   import fcv_pkg::*;
   `include "fp32_fp16_converter_assert.svh"

   logic      v1, v2;
   stage_type s1, s2;
   logic [23:0] shifted;
   logic [3:0]  lead;

   assign busy = 1'b0;

   fcv_classify u_classify (
      .clock(clock), .reset(reset), .in_valid(start & ~busy), .in_kind(req_kind),
      .in_operand(req_operand), .out_valid(v1), .out_stage(s1)
   );
   fcv_align u_align (
      .clock(clock), .reset(reset), .in_valid(v1), .in_stage(s1),
      .out_valid(v2), .out_stage(s2), .out_shifted(shifted), .out_lead(lead)
   );
   fcv_pack u_pack (
      .clock(clock), .reset(reset), .in_valid(v2), .in_stage(s2),
      .in_shifted(shifted), .in_lead(lead), .out_valid(rsp_strobe), .out_result(rsp_result)
   );

   `FCV_ASSERT_NXT(a_lat1, clock, reset, start && !busy, v1)
   `FCV_ASSERT_NXT(a_lat2, clock, reset, v2, rsp_strobe)
   `FCV_ASSERT_IMP(a_half_upper, clock, reset, rsp_strobe && $past(s2.kind == KIND_S2H),
                   rsp_result[31:16] == 16'd0)
endmodule
